// File: sv/keyword_substitution_cipher_core_assert.svh
// Assertion macros for the keyword substitution cipher core
`ifndef KEYWORD_SUBSTITUTION_CIPHER_CORE_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define KSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyword cipher check failed");
// next-cycle implication
`define KSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyword cipher check failed");
`else
`define KSC_ASSERT_IMPL(lbl, ante, cons)
`define KSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: sv/ksc_pkg.sv
// Shared constants and controller/datapath interface types for the cipher core
package ksc_pkg;

  localparam int ALPHABET_SIZE_DEF = 26;

  localparam logic [7:0] LETTER_A = 8'h61;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_KEY   = 2'd1;
  localparam logic [1:0] FUNC_PLAIN = 2'd2;

  typedef struct packed {
    logic capture;      // latch the incoming byte
    logic clear;        // start a new keyword
    logic kw_load;      // offer a keyword byte
    logic build_start;  // set up the table walk
    logic build_step;   // one letter of the walk
    logic rd_en;        // read both stores
    logic rd_from_reg;  // address from latched byte, not the input
    logic out_load;     // load the result register
  } ksc_cmd_t;

  typedef struct packed {
    logic tbl_ready;
    logic walk_last;
  } ksc_sts_t;

endpackage

// File: sv/keyword_substitution_cipher_core.sv
// Plaintext item: the stores are read into registers, then the result register is loaded.
// After a keyword change the first plaintext item first walks the table (one letter
// per cycle) and then re-reads the stores with the latched byte as address.
// Clear and keyword items give no result.
// A new item is accepted only after the result of a plaintext item has been loaded.
// Synchronous active-low reset empties the keyword and marks the table stale.
module keyword_substitution_cipher_core #(
  parameter int ALPHABET_SIZE = ksc_pkg::ALPHABET_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_data_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_cipher_char
);
  import ksc_pkg::*;

  `include "keyword_substitution_cipher_core_assert.svh"

  ksc_cmd_t cmd;
  ksc_sts_t sts;

  ksc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ksc_dpath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_char    (in_data_char),
    .cmd             (cmd),
    .sts             (sts),
    .out_cipher_char (out_cipher_char)
  );

  `KSC_ASSERT_NEXT(a_busy_after_plain, in_valid && in_ready && in_func == FUNC_PLAIN, !in_ready)
  `KSC_ASSERT_NEXT(a_no_result_other, in_valid && in_ready && in_func != FUNC_PLAIN && !out_valid, !out_valid)
  `KSC_ASSERT_IMPL(a_read_needs_table, cmd.rd_en, sts.tbl_ready)

endmodule

// File: sv/ksc_ctrl.sv
// Sequencing state machine of the cipher core
module ksc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ksc_pkg::ksc_sts_t sts,
  output ksc_pkg::ksc_cmd_t cmd
);
  import ksc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BUILD = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (in_func)
            FUNC_CLEAR: cmd.clear = 1'b1;
            FUNC_KEY:   cmd.kw_load = 1'b1;
            FUNC_PLAIN: begin
              if (sts.tbl_ready) begin
                cmd.rd_en = 1'b1;
                state_nxt = ST_FIN;
              end else begin
                cmd.build_start = 1'b1;
                state_nxt       = ST_BUILD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_BUILD: begin
        cmd.build_step = 1'b1;
        if (sts.walk_last) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en       = 1'b1;
        cmd.rd_from_reg = 1'b1;
        state_nxt       = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/ksc_dpath.sv
// Keyword stores, table walk and lookup datapath of the cipher core
module ksc_dpath #(
  parameter int ALPHABET_SIZE = ksc_pkg::ALPHABET_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_data_char,
  input  ksc_pkg::ksc_cmd_t cmd,
  output ksc_pkg::ksc_sts_t sts,
  output logic [7:0]        out_cipher_char
);
  import ksc_pkg::*;

  localparam int IW = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int CW = $clog2(ALPHABET_SIZE + 1);
  localparam logic [7:0]    N8   = 8'(ALPHABET_SIZE);
  localparam logic [CW-1:0] NCNT = CW'(ALPHABET_SIZE);
  localparam logic [IW-1:0] LAST = IW'(ALPHABET_SIZE - 1);

  logic [ALPHABET_SIZE-1:0] used_r;
  logic [CW-1:0]            count_r;
  logic                     ready_r;
  logic [7:0]               char_r;
  logic [IW-1:0]            walk_r;   // letter under test, counts down
  logic [CW-1:0]            pos_r;    // next table position to fill
  logic [IW-1:0]            kw_mem  [ALPHABET_SIZE];
  logic [IW-1:0]            tbl_mem [ALPHABET_SIZE];
  logic [IW-1:0]            kw_rd_r, tbl_rd_r;
  logic [7:0]               out_r;

  logic [7:0]    in_diff, reg_diff, rd_diff;
  logic          in_letter, reg_letter;
  logic [IW-1:0] in_idx, rd_idx, reg_idx;
  logic          kw_keep, walk_write;
  logic [IW-1:0] sel_letter;

  assign in_diff    = in_data_char - LETTER_A;
  assign in_letter  = (in_data_char >= LETTER_A) && (in_diff < N8);
  assign in_idx     = in_diff[IW-1:0];
  assign reg_diff   = char_r - LETTER_A;
  assign reg_letter = (char_r >= LETTER_A) && (reg_diff < N8);
  assign reg_idx    = reg_diff[IW-1:0];
  assign rd_diff    = cmd.rd_from_reg ? reg_diff : in_diff;
  assign rd_idx     = rd_diff[IW-1:0];

  assign kw_keep    = cmd.kw_load && in_letter && !used_r[in_idx] && (count_r < NCNT);
  assign walk_write = cmd.build_step && !used_r[walk_r];

  assign sts.tbl_ready = ready_r;
  assign sts.walk_last = (walk_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      count_r <= '0;
      ready_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        used_r  <= '0;
        count_r <= '0;
        ready_r <= 1'b0;
      end else if (kw_keep) begin
        used_r[in_idx] <= 1'b1;
        count_r        <= count_r + 1'b1;
        ready_r        <= 1'b0;
      end else if (cmd.build_step && walk_r == '0) begin
        ready_r <= 1'b1;
      end
    end
  end

  // byte latch, walk counters, kept letters, the descending remainder of the table, store reads and result
  always_ff @(posedge clk) begin
    if (cmd.capture) char_r <= in_data_char;
    if (cmd.build_start) begin
      walk_r <= LAST;
      pos_r  <= count_r;
    end else if (cmd.build_step) begin
      walk_r <= walk_r - 1'b1;
      if (walk_write) pos_r <= pos_r + 1'b1;
    end
    if (kw_keep) kw_mem[count_r[IW-1:0]] <= in_idx;
    if (walk_write) tbl_mem[pos_r[IW-1:0]] <= walk_r;
    if (cmd.rd_en) begin
      kw_rd_r  <= kw_mem[rd_idx];
      tbl_rd_r <= tbl_mem[rd_idx];
    end
    if (cmd.out_load) out_r <= reg_letter ? (LETTER_A + 8'(sel_letter)) : char_r;
  end

  // positions below the keyword length come straight from the keyword store
  assign sel_letter = (CW'(reg_idx) < count_r) ? kw_rd_r : tbl_rd_r;

  assign out_cipher_char = out_r;

endmodule
